[rtl/core/tlc_pkg.sv]
package tlc_pkg;

	localparam int ADDR_W    = 32;
	localparam int LAT_W     = 12;
	localparam int CFG_W     = 10;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LOG2     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALLOCATE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_L1_LATENCY     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_L2_LATENCY     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_LATENCY = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOOK,
		ST_EV_RD,
		ST_EV_L1,
		ST_EV_L2,
		ST_AL_RD,
		ST_AL_L1,
		ST_WB_RD,
		ST_WB_L2,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		ROW_PUT,
		ROW_DROP,
		ROW_ALLOC
	} row_op_t;

	typedef struct packed {
		row_op_t op;
		logic    keep;
		logic    dval;
	} row_ctl_t;

	typedef struct packed {
		logic hit;
		logic full;
		logic drop_dirty;
	} row_stat_t;

endpackage

[rtl/core/tlc_if.sv]
interface tlc_req_if import tlc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              cmd;
	logic [ADDR_W-1:0] address;

	modport source(output valid, cmd, address, input ready);
	modport sink(input valid, cmd, address, output ready);
endinterface

interface tlc_rsp_if import tlc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [LAT_W-1:0] latency;
	logic             l1_hit;
	logic             l2_accessed;
	logic             l2_hit;
	logic             memory_writeback;

	modport source(output valid, latency, l1_hit, l2_accessed, l2_hit, memory_writeback,
		input ready);
	modport sink(input valid, latency, l1_hit, l2_accessed, l2_hit, memory_writeback,
		output ready);
endinterface

[rtl/core/tlc_ram.sv]
module tlc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/tlc_row.sv]
module tlc_row import tlc_pkg::*; #(
	parameter int WAYS_LOG2 = 2,
	parameter int TAG_W = 26,
	localparam int W = 1 << WAYS_LOG2,
	localparam int RW = (WAYS_LOG2 == 0) ? 1 : WAYS_LOG2
) (
	input  logic [W-1:0][TAG_W-1:0] tags,
	input  logic [W-1:0]            valid,
	input  logic [W-1:0]            dirty,
	input  logic [W-1:0][RW-1:0]    rank,
	input  logic [TAG_W-1:0]        lookup_tag,
	input  row_ctl_t                ctl,
	output logic [W-1:0][TAG_W-1:0] new_tags,
	output logic [W-1:0]            new_valid,
	output logic [W-1:0]            new_dirty,
	output logic [W-1:0][RW-1:0]    new_rank,
	output row_stat_t               stat,
	output logic [TAG_W-1:0]        victim_tag
);

	logic [RW-1:0] hit_way, fw, vw, best;
	logic          hit, free;

	always_comb begin
		hit     = 1'b0;
		hit_way = '0;
		free    = 1'b0;
		fw      = '0;
		vw      = '0;
		best    = '0;
		for (int j = 0; j < W; j++) begin
			if (valid[j] && tags[j] == lookup_tag) begin
				hit     = 1'b1;
				hit_way = RW'(j);
			end
			if (rank[j] >= best) begin
				best = rank[j];
				vw   = RW'(j);
			end
		end
		for (int j = W - 1; j >= 0; j--) begin
			if (!valid[j]) begin
				free = 1'b1;
				fw   = RW'(j);
			end
		end
	end

	logic                  do_drop, do_put;
	logic [RW-1:0]         dw, pw;
	logic [W-1:0][TAG_W-1:0] a_tags;
	logic [W-1:0]          a_valid, a_dirty;
	logic [W-1:0][RW-1:0]  a_rank;

	always_comb begin
		do_drop = 1'b0;
		dw      = hit_way;
		do_put  = 1'b0;
		pw      = hit ? hit_way : fw;
		case (ctl.op)
			ROW_DROP: begin
				do_drop = hit;
			end
			ROW_ALLOC: begin
				do_drop = !free;
				dw      = vw;
				do_put  = 1'b1;
				pw      = free ? fw : vw;
			end
			default: begin
				do_put = hit || free;
			end
		endcase

		a_tags  = tags;
		a_valid = valid;
		a_dirty = dirty;
		a_rank  = rank;
		if (do_drop) begin
			for (int j = 0; j < W; j++) begin
				if (RW'(j) != dw && valid[j] && rank[j] > rank[dw]) begin
					a_rank[j] = RW'(rank[j] - 1'b1);
				end
			end
			a_tags[dw]  = '0;
			a_valid[dw] = 1'b0;
			a_dirty[dw] = 1'b0;
			a_rank[dw]  = '0;
		end

		new_tags  = a_tags;
		new_valid = a_valid;
		new_dirty = a_dirty;
		new_rank  = a_rank;
		if (do_put) begin
			for (int j = 0; j < W; j++) begin
				if (RW'(j) != pw && a_valid[j] && (!a_valid[pw] || a_rank[j] < a_rank[pw]))
				begin
					new_rank[j] = RW'(a_rank[j] + 1'b1);
				end
			end
			new_rank[pw]  = '0;
			new_tags[pw]  = lookup_tag;
			new_valid[pw] = 1'b1;
			new_dirty[pw] = (ctl.op == ROW_PUT && ctl.keep) ? a_dirty[pw] : ctl.dval;
		end
	end

	assign stat.hit        = hit;
	assign stat.full       = !free;
	assign stat.drop_dirty = do_drop && dirty[dw];
	assign victim_tag      = tags[vw];

endmodule

[rtl/core/two_level_cache_lru_model.sv]
// An access looks up both set memories; an L1 hit or a write-around then finishes,
// an L1 miss updates L2 and fills L1, a dirty L1 victim then goes back to L2, and an
// L2 victim is first dropped from L1. The next word is accepted once the sequencer is idle.
// Each step is a read-modify-write of a set row through the set memories.
// Reset clears a valid flag per set, so the set memories need no clearing pass.
module two_level_cache_lru_model import tlc_pkg::*; #(
	parameter int L1_SETS_LOG2 = 6,
	parameter int L1_WAYS_LOG2 = 2,
	parameter int L2_SETS_LOG2 = 8,
	parameter int L2_WAYS_LOG2 = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	tlc_req_if.sink              req,
	tlc_rsp_if.source            rsp
);

	localparam int W1    = 1 << L1_WAYS_LOG2;
	localparam int RW1   = (L1_WAYS_LOG2 == 0) ? 1 : L1_WAYS_LOG2;
	localparam int TW1   = ADDR_W - L1_SETS_LOG2;
	localparam int ROW1  = W1 * (TW1 + 2 + RW1);
	localparam int SETS1 = 1 << L1_SETS_LOG2;
	localparam int AW1   = (L1_SETS_LOG2 == 0) ? 1 : L1_SETS_LOG2;
	localparam logic [31:0] M1 = 32'((64'd1 << L1_SETS_LOG2) - 64'd1);

	localparam int W2    = 1 << L2_WAYS_LOG2;
	localparam int RW2   = (L2_WAYS_LOG2 == 0) ? 1 : L2_WAYS_LOG2;
	localparam int TW2   = ADDR_W - L2_SETS_LOG2;
	localparam int ROW2  = W2 * (TW2 + 2 + RW2);
	localparam int SETS2 = 1 << L2_SETS_LOG2;
	localparam int AW2   = (L2_SETS_LOG2 == 0) ? 1 : L2_SETS_LOG2;
	localparam logic [31:0] M2 = 32'((64'd1 << L2_SETS_LOG2) - 64'd1);

	function automatic logic [AW1-1:0] set1_of(input logic [31:0] a, input logic [3:0] b);
		logic [31:0] s;
		s = a >> b;
		return AW1'(s & M1);
	endfunction

	function automatic logic [AW2-1:0] set2_of(input logic [31:0] a, input logic [3:0] b);
		logic [31:0] s;
		s = a >> b;
		return AW2'(s & M2);
	endfunction

	function automatic logic [TW1-1:0] tag1_of(input logic [31:0] a, input logic [3:0] b);
		logic [5:0] sh;
		sh = 6'(b) + 6'(L1_SETS_LOG2);
		return TW1'(a >> sh);
	endfunction

	function automatic logic [TW2-1:0] tag2_of(input logic [31:0] a, input logic [3:0] b);
		logic [5:0] sh;
		sh = 6'(b) + 6'(L2_SETS_LOG2);
		return TW2'(a >> sh);
	endfunction

	function automatic logic [31:0] va1_of(input logic [TW1-1:0] t, input logic [AW1-1:0] s,
		input logic [3:0] b);
		logic [31:0] v;
		v = (32'(t) << L1_SETS_LOG2) | 32'(s);
		return v << b;
	endfunction

	function automatic logic [31:0] va2_of(input logic [TW2-1:0] t, input logic [AW2-1:0] s,
		input logic [3:0] b);
		logic [31:0] v;
		v = (32'(t) << L2_SETS_LOG2) | 32'(s);
		return v << b;
	endfunction

	logic [3:0] blk_q;
	logic       wa_q;
	logic [9:0] l1_lat_q, l2_lat_q, mem_lat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_q     <= 4'd4;
			wa_q      <= 1'b1;
			l1_lat_q  <= 10'd1;
			l2_lat_q  <= 10'd5;
			mem_lat_q <= 10'd100;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BLOCK_LOG2:     blk_q     <= cfg_data[3:0];
				CFG_WRITE_ALLOCATE: wa_q      <= cfg_data[0];
				CFG_L1_LATENCY:     l1_lat_q  <= cfg_data;
				CFG_L2_LATENCY:     l2_lat_q  <= cfg_data;
				CFG_MEMORY_LATENCY: mem_lat_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	state_t state_q, state_d;

	logic            re1, we1, re2, we2;
	logic [AW1-1:0]  ra1, ra1_q;
	logic [AW2-1:0]  ra2, ra2_q;
	logic [ROW1-1:0] rd1, wd1;
	logic [ROW2-1:0] rd2, wd2;
	logic [SETS1-1:0] rowv1_q;
	logic [SETS2-1:0] rowv2_q;
	logic            rv1_q, rv2_q;

	tlc_ram #(.WIDTH(ROW1), .DEPTH(SETS1)) u_l1_ram (
		.clk(clk), .we(we1), .waddr(ra1_q), .wdata(wd1),
		.re(re1), .raddr(ra1), .rdata(rd1)
	);

	tlc_ram #(.WIDTH(ROW2), .DEPTH(SETS2)) u_l2_ram (
		.clk(clk), .we(we2), .waddr(ra2_q), .wdata(wd2),
		.re(re2), .raddr(ra2), .rdata(rd2)
	);

	logic [W1-1:0][TW1-1:0] t1, nt1;
	logic [W1-1:0]          v1, d1, nv1, nd1;
	logic [W1-1:0][RW1-1:0] r1, nr1;
	logic [W2-1:0][TW2-1:0] t2, nt2;
	logic [W2-1:0]          v2, d2, nv2, nd2;
	logic [W2-1:0][RW2-1:0] r2, nr2;

	assign {t1, v1, d1, r1} = rv1_q ? rd1 : '0;
	assign {t2, v2, d2, r2} = rv2_q ? rd2 : '0;
	assign wd1 = {nt1, nv1, nd1, nr1};
	assign wd2 = {nt2, nv2, nd2, nr2};

	logic [TW1-1:0] lt1, vt1;
	logic [TW2-1:0] lt2, vt2;
	row_ctl_t       ctl1, ctl2;
	row_stat_t      st1, st2;

	tlc_row #(.WAYS_LOG2(L1_WAYS_LOG2), .TAG_W(TW1)) u_l1_row (
		.tags(t1), .valid(v1), .dirty(d1), .rank(r1), .lookup_tag(lt1), .ctl(ctl1),
		.new_tags(nt1), .new_valid(nv1), .new_dirty(nd1), .new_rank(nr1),
		.stat(st1), .victim_tag(vt1)
	);

	tlc_row #(.WAYS_LOG2(L2_WAYS_LOG2), .TAG_W(TW2)) u_l2_row (
		.tags(t2), .valid(v2), .dirty(d2), .rank(r2), .lookup_tag(lt2), .ctl(ctl2),
		.new_tags(nt2), .new_valid(nv2), .new_dirty(nd2), .new_rank(nr2),
		.stat(st2), .victim_tag(vt2)
	);

	logic        cmd_q, d1_q, wb_q, l1hit_q, l2acc_q, l2hit_q;
	logic [31:0] addr_q, va_q;
	logic [LAT_W-1:0] lat_q;
	logic        out_valid_q;
	logic        out_load;

	always_comb begin
		state_d  = state_q;
		re1      = 1'b0;
		re2      = 1'b0;
		we1      = 1'b0;
		we2      = 1'b0;
		ra1      = set1_of(addr_q, blk_q);
		ra2      = set2_of(addr_q, blk_q);
		lt1      = tag1_of(addr_q, blk_q);
		lt2      = tag2_of(addr_q, blk_q);
		ctl1     = '{op: ROW_PUT, keep: !cmd_q, dval: 1'b1};
		ctl2     = '{op: ROW_PUT, keep: 1'b0, dval: 1'b1};
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				ra1 = set1_of(req.address, blk_q);
				ra2 = set2_of(req.address, blk_q);
				if (req.valid) begin
					re1     = 1'b1;
					re2     = 1'b1;
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (st1.hit) begin
					we1     = 1'b1;
					state_d = ST_DONE;
				end else if (cmd_q && !wa_q) begin
					we2     = st2.hit;
					state_d = ST_DONE;
				end else if (st2.hit) begin
					ctl2    = '{op: ROW_PUT, keep: !cmd_q, dval: 1'b0};
					we2     = 1'b1;
					state_d = ST_AL_RD;
				end else if (!st2.full) begin
					ctl2    = '{op: ROW_ALLOC, keep: 1'b0, dval: 1'b0};
					we2     = 1'b1;
					state_d = ST_AL_RD;
				end else begin
					state_d = ST_EV_RD;
				end
			end
			ST_EV_RD: begin
				ra1     = set1_of(va_q, blk_q);
				re1     = 1'b1;
				state_d = ST_EV_L1;
			end
			ST_EV_L1: begin
				lt1     = tag1_of(va_q, blk_q);
				ctl1    = '{op: ROW_DROP, keep: 1'b0, dval: 1'b0};
				we1     = 1'b1;
				state_d = ST_EV_L2;
			end
			ST_EV_L2: begin
				ctl2    = '{op: ROW_ALLOC, keep: 1'b0, dval: 1'b0};
				we2     = 1'b1;
				state_d = ST_AL_RD;
			end
			ST_AL_RD: begin
				re1     = 1'b1;
				state_d = ST_AL_L1;
			end
			ST_AL_L1: begin
				ctl1    = '{op: ROW_ALLOC, keep: 1'b0, dval: cmd_q};
				we1     = 1'b1;
				state_d = st1.drop_dirty ? ST_WB_RD : ST_DONE;
			end
			ST_WB_RD: begin
				ra2     = set2_of(va_q, blk_q);
				re2     = 1'b1;
				state_d = ST_WB_L2;
			end
			ST_WB_L2: begin
				lt2     = tag2_of(va_q, blk_q);
				we2     = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			rowv1_q     <= '0;
			rowv2_q     <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (we1) begin
				rowv1_q[ra1_q] <= 1'b1;
			end
			if (we2) begin
				rowv2_q[ra2_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (re1) begin
			ra1_q <= ra1;
			rv1_q <= rowv1_q[ra1];
		end
		if (re2) begin
			ra2_q <= ra2;
			rv2_q <= rowv2_q[ra2];
		end
		if (state_q == ST_IDLE && req.valid) begin
			cmd_q  <= req.cmd;
			addr_q <= req.address;
			wb_q   <= 1'b0;
		end
		if (state_q == ST_LOOK) begin
			l1hit_q <= st1.hit;
			l2acc_q <= !st1.hit;
			l2hit_q <= !st1.hit && st2.hit;
			lat_q   <= LAT_W'(l1_lat_q) + (st1.hit ? '0 :
				LAT_W'(l2_lat_q) + (st2.hit ? '0 : LAT_W'(mem_lat_q)));
			va_q    <= va2_of(vt2, set2_of(addr_q, blk_q), blk_q);
		end
		if (state_q == ST_EV_L1) begin
			d1_q <= st1.drop_dirty;
		end
		if (state_q == ST_EV_L2) begin
			wb_q <= st2.drop_dirty | d1_q;
		end
		if (state_q == ST_AL_L1) begin
			va_q <= va1_of(vt1, set1_of(addr_q, blk_q), blk_q);
		end
		if (out_load) begin
			rsp.latency          <= lat_q;
			rsp.l1_hit           <= l1hit_q;
			rsp.l2_accessed      <= l2acc_q;
			rsp.l2_hit           <= l2hit_q;
			rsp.memory_writeback <= wb_q;
		end
	end

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = out_valid_q;

	a_hit_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.l1_hit != rsp.l2_accessed) && !(rsp.l2_hit && !rsp.l2_accessed))
		else $error("hit flags of a result word disagree");

	a_wb_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.memory_writeback |-> rsp.l2_accessed && !rsp.l2_hit)
		else $error("write-back reported without an L2 miss");

	a_accept_look: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> state_q == ST_LOOK)
		else $error("accepted word did not start a lookup");

	a_l1_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(we1 && re1) && !(we2 && re2))
		else $error("set memory read and written in the same cycle");

endmodule
